[hdl/ppdvc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppdvc_pkg: shared types, constants and microcode for the pendulum controller
// Holds the beat structs, the register map, the micro-op set and the program
// that the sequencer steps through for one control step.
// ----------------------------------------------------------------------------
package ppdvc_pkg;

	// Beat payloads.
	typedef struct packed {
		logic signed [15:0] encoder_count;
		logic signed [15:0] measured_velocity;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] drive_command;
		logic signed [11:0] angle;
	} out_item_t;

	// Configuration register file.
	localparam int CFG_DATA_W  = 15;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KP_GAIN        = 3'd0,
		REG_KD_GAIN        = 3'd1,
		REG_DEADBAND       = 3'd2,
		REG_CUTOFF         = 3'd3,
		REG_VELOCITY_LIMIT = 3'd4,
		REG_VELOCITY_GAIN  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  kp_gain;
		logic [7:0]  kd_gain;
		logic [10:0] deadband;
		logic [10:0] cutoff;
		logic [14:0] velocity_limit;
		logic [7:0]  velocity_gain;
	} cfg_t;

	localparam logic [7:0]  KP_RESET    = 8'd4;
	localparam logic [7:0]  KD_RESET    = 8'd30;
	localparam logic [10:0] DB_RESET    = 11'd70;
	localparam logic [10:0] CUT_RESET   = 11'd400;
	localparam logic [14:0] LIMIT_RESET = 15'd2000;
	localparam logic [7:0]  VG_RESET    = 8'd4;

	// Arithmetic limits.
	localparam int ACC_W = 26;
	localparam logic signed [11:0] ANGLE_MAX = 12'sh7FF;
	localparam logic signed [11:0] ANGLE_MIN = 12'sh800;
	localparam logic signed [15:0] DRIVE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] DRIVE_MIN = 16'sh8000;

	// Micro-operations understood by the datapath.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_MODQ,
		OP_MODR,
		OP_WRAP,
		OP_SAT,
		OP_DEAD,
		OP_CUT,
		OP_PTERM,
		OP_DTERM,
		OP_CLAMP,
		OP_ERR,
		OP_MULV
	} uop_t;

	typedef enum logic {
		COND_NONE,
		COND_CUT
	} ucond_t;

	localparam int STEP_W = 4;

	typedef struct packed {
		uop_t              op;
		ucond_t            cond;
		logic [STEP_W-1:0] target;
		logic              last;
	} uword_t;

	// Sequencer to datapath.
	typedef struct packed {
		logic start;
		logic exec;
		uop_t op;
	} ctrl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic cut;
	} flags_t;

	localparam logic [STEP_W-1:0] STEP_CLAMP = 4'd9;

	// The control program. Step 6 skips the PD terms when the angle is beyond
	// the cutoff; the accumulator was already cleared by the CUT step.
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
		uword_t w;
		w = '{op: OP_NOP, cond: COND_NONE, target: '0, last: 1'b0};
		case (addr)
			4'd0:  w.op = OP_MODQ;
			4'd1:  w.op = OP_MODR;
			4'd2:  w.op = OP_WRAP;
			4'd3:  w.op = OP_SAT;
			4'd4:  w.op = OP_DEAD;
			4'd5:  w.op = OP_CUT;
			4'd6: begin
				w.cond   = COND_CUT;
				w.target = STEP_CLAMP;
			end
			4'd7:  w.op = OP_PTERM;
			4'd8:  w.op = OP_DTERM;
			4'd9:  w.op = OP_CLAMP;
			4'd10: w.op = OP_ERR;
			4'd11: w.op = OP_MULV;
			4'd12: w.last = 1'b1;
			default: w.last = 1'b1;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[hdl/ppdvc_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppdvc_sequencer: microcode step counter
// Steps through the control program, takes conditional jumps on datapath
// flags and holds on the final step while the result register is occupied.
// ----------------------------------------------------------------------------
module ppdvc_sequencer
	import ppdvc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire logic   hold,
	input  wire flags_t flags,
	output ctrl_t       ctrl,
	output logic        busy,
	output logic        done
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	uword_t            uw;
	logic              stall;
	logic              jump;

	always_comb begin
		uw        = ucode_rom(step_q);
		stall     = uw.last && hold;
		jump      = (uw.cond == COND_CUT) && flags.cut;
		ctrl.start = start;
		ctrl.exec  = busy_q && !stall;
		ctrl.op    = uw.op;
		done       = busy_q && uw.last && !hold;
		busy       = busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && !stall) begin
			if (uw.last) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else if (jump) begin
				step_q <= uw.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/ppdvc_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ppdvc_datapath: arithmetic for one control step
// Wraps the encoder count into an angle, applies deadband and cutoff, forms
// the PD target, clamps it and scales the velocity error into a drive.
// ----------------------------------------------------------------------------
module ppdvc_datapath
	import ppdvc_pkg::*;
#(
	parameter int COUNTS_PER_REV = 4096
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctrl_t    ctrl,
	input  wire cfg_t     cfg,
	input  wire in_item_t in_item,
	output flags_t        flags,
	output out_item_t     result
);

	// Wrap by reciprocal: the count is biased so that a plain modulo lands
	// directly on the centred angle once the half revolution is removed.
	localparam int REV   = COUNTS_PER_REV;
	localparam int HALF  = REV / 2;
	localparam int OFF   = REV - HALF;
	localparam int BIAS  = 32768 + ((OFF - (32768 % REV) + REV) % REV);
	localparam int QSH   = 17;
	localparam int RECIP = (1 << QSH) / REV;

	logic [16:0]              u_q;
	logic [16:0]              q_q;
	logic [17:0]              r_q;
	logic signed [17:0]       w_q;
	logic signed [11:0]       ang_q;
	logic signed [11:0]       prev_q;
	logic signed [12:0]       diff_q;
	logic                     cut_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [15:0]       tgt_q;
	logic signed [15:0]       vel_q;
	logic signed [16:0]       err_q;

	logic [17:0]              u_sum;
	logic [33:0]              q_prod;
	logic [33:0]              qr_prod;
	logic [17:0]              r_next;
	logic                     r_ge;
	logic [17:0]              t_val;
	logic signed [17:0]       w_next;
	logic [11:0]              ang_mag;
	logic signed [12:0]       diff_next;
	logic signed [20:0]       p_term;
	logic signed [21:0]       d_term;
	logic signed [25:0]       v_term;
	logic signed [ACC_W-1:0]  lim_hi;
	logic signed [ACC_W-1:0]  lim_lo;

	always_comb begin
		u_sum     = {{2{in_item.encoder_count[15]}}, in_item.encoder_count} + 18'(BIAS);
		q_prod    = 34'(u_q) * 34'(RECIP);
		qr_prod   = 34'(q_q) * 34'(REV);
		r_next    = {1'b0, u_q} - qr_prod[17:0];
		r_ge      = r_q >= 18'(REV);
		t_val     = r_ge ? (r_q - 18'(REV)) : r_q;
		w_next    = $signed(t_val - 18'(OFF));
		ang_mag   = ang_q[11] ? 12'(-ang_q) : 12'(ang_q);
		diff_next = 13'(ang_q) - 13'(prev_q);
		p_term    = ang_q * $signed({1'b0, cfg.kp_gain});
		d_term    = diff_q * $signed({1'b0, cfg.kd_gain});
		v_term    = err_q * $signed({1'b0, cfg.velocity_gain});
		lim_hi    = $signed(ACC_W'(cfg.velocity_limit));
		lim_lo    = -lim_hi;
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			u_q   <= u_sum[16:0];
			vel_q <= in_item.measured_velocity;
		end else if (ctrl.exec) begin
			case (ctrl.op)
				OP_MODQ:  q_q <= q_prod[QSH+16:QSH];
				OP_MODR:  r_q <= r_next;
				OP_WRAP:  w_q <= w_next;
				OP_SAT: begin
					if (w_q > 18'(ANGLE_MAX))
						ang_q <= ANGLE_MAX;
					else if (w_q < 18'(ANGLE_MIN))
						ang_q <= ANGLE_MIN;
					else
						ang_q <= w_q[11:0];
				end
				OP_DEAD: begin
					if (ang_mag < {1'b0, cfg.deadband})
						ang_q <= '0;
				end
				OP_CUT: begin
					cut_q  <= ang_mag > {1'b0, cfg.cutoff};
					diff_q <= diff_next;
					acc_q  <= '0;
				end
				OP_PTERM: acc_q <= ACC_W'(p_term);
				OP_DTERM: acc_q <= acc_q + ACC_W'(d_term);
				OP_CLAMP: begin
					if (acc_q > lim_hi)
						tgt_q <= 16'(lim_hi);
					else if (acc_q < lim_lo)
						tgt_q <= 16'(lim_lo);
					else
						tgt_q <= 16'(acc_q);
				end
				OP_ERR:   err_q <= 17'(tgt_q) - 17'(vel_q);
				OP_MULV:  acc_q <= ACC_W'(v_term);
				default: begin
				end
			endcase
		end
	end

	// The previous angle is state across items, so it is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctrl.exec && ctrl.op == OP_CUT) begin
			prev_q <= ang_q;
		end
	end

	always_comb begin
		flags.cut    = cut_q;
		result.angle = ang_q;
		if (acc_q > ACC_W'(DRIVE_MAX))
			result.drive_command = DRIVE_MAX;
		else if (acc_q < ACC_W'(DRIVE_MIN))
			result.drive_command = DRIVE_MIN;
		else
			result.drive_command = acc_q[15:0];
	end

endmodule
`default_nettype wire

[hdl/pendulum_pd_velocity_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pendulum_pd_velocity_controller: PD balancing step with deadband
// One input beat (encoder count, measured velocity) gives one output beat
// (saturated drive command, wrapped angle after the deadband).
// ----------------------------------------------------------------------------
// Usage notes.
// Input and output channels are valid/ready; a beat moves when both are high.
// in_ready is high whenever the microcode sequencer is idle, so one control
// step is worked on at a time.
// After an input beat is accepted the sequencer runs its program, one step
// per cycle unless held on its final step, through a single shared datapath:
// the output beat appears once the program ends, sooner when the angle is
// beyond the cutoff and the PD terms are skipped. The next input beat can be
// taken once the result is loaded, not before, so the program length sets
// how often a new item is accepted.
// The result sits in an output register. If the receiver stalls, the
// sequencer holds on its final step until that register is free; a beat
// waiting in the output register does not stop a new input being accepted.
// Reset clears the sequencer, the output valid flag and the stored previous
// angle, and loads every configuration register with its default value.
// Configuration must be written through cfg_wr_en / cfg_index / cfg_data while
// the block is idle (not enforced by the block); unknown indices are ignored.
// ----------------------------------------------------------------------------
module pendulum_pd_velocity_controller
	import ppdvc_pkg::*;
#(
	parameter int COUNTS_PER_REV = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire in_item_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output out_item_t                   out_data,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	out_item_t out_q;
	logic      out_valid_q;

	ctrl_t     ctrl;
	flags_t    flags;
	out_item_t result;
	logic      busy;
	logic      done;
	logic      start;
	logic      hold;

	// An item is started on the accepting edge; the result register must be
	// empty, or emptied this cycle, before the final step may complete.
	assign in_ready  = !busy;
	assign start     = in_valid && in_ready;
	assign hold      = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers. Every write is masked to the register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain        <= KP_RESET;
			cfg_q.kd_gain        <= KD_RESET;
			cfg_q.deadband       <= DB_RESET;
			cfg_q.cutoff         <= CUT_RESET;
			cfg_q.velocity_limit <= LIMIT_RESET;
			cfg_q.velocity_gain  <= VG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KP_GAIN:        cfg_q.kp_gain        <= cfg_data[7:0];
				REG_KD_GAIN:        cfg_q.kd_gain        <= cfg_data[7:0];
				REG_DEADBAND:       cfg_q.deadband       <= cfg_data[10:0];
				REG_CUTOFF:         cfg_q.cutoff         <= cfg_data[10:0];
				REG_VELOCITY_LIMIT: cfg_q.velocity_limit <= cfg_data[14:0];
				REG_VELOCITY_GAIN:  cfg_q.velocity_gain  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	ppdvc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hold   (hold),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	ppdvc_datapath #(
		.COUNTS_PER_REV (COUNTS_PER_REV)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.cfg     (cfg_q),
		.in_item (in_data),
		.flags   (flags),
		.result  (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= result;
	end

	// An accepted beat keeps the sequencer busy into the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("sequencer idle straight after accepting a beat");

	// A result may only be loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken output beat");

	// Output valid only ever rises as the program completes.
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(done))
		else $error("output beat appeared without a completed step");

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for the pendulum PD velocity controller
// Drives control-step beats through the valid/ready channels under random idle
// gaps and output stalls, predicts every drive command and wrapped angle from
// its own copy of the controller state and registers, and checks each output
// beat in order across directed edge cases and randomised register settings.
// ----------------------------------------------------------------------------
module testbench;
	import ppdvc_pkg::*;

	// The block is built with the default encoder resolution.
	localparam int REV_COUNTS = 4096;

	// Indices past the register map. Writes to these must leave every register
	// as it was.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	// This many quiet cycles are enough for the sequencer to go back to idle.
	localparam int SETTLE_CYCLES    = 16;
	localparam int LONG_HOLD_CYCLES = 60;
	// The longest correct stretch without a beat comes from the long hold, so
	// this limit leaves a wide margin.
	localparam int WATCHDOG_LIMIT   = 2000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Mirror of the controller: register file and the angle of the last step.
	cfg_t active_settings = '{KP_RESET, KD_RESET, DB_RESET, CUT_RESET, LIMIT_RESET,
		VG_RESET};
	logic signed [11:0] held_angle = '0;

	// Drive commands and angles still owed by the block, oldest first.
	out_item_t pending_commands[$];

	bit idle_on       = 1'b1;
	int hold_requests = 0;
	int holds_served  = 0;
	int stall_left    = 0;
	int walk_angle    = 0;
	int beats_sent    = 0;
	int results_checked  = 0;
	int settings_applied = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	pendulum_pd_velocity_controller #(
		.COUNTS_PER_REV(REV_COUNTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	function automatic longint saturate(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// One control step. Everything is worked at 64 bits and only the explicit
	// saturations limit it, so the block must saturate wherever a narrow
	// datapath would otherwise wrap.
	function automatic out_item_t compute_control_step(in_item_t beat);
		longint count, vel, ang, mag, target, limit, drive;
		out_item_t result;
		count = longint'(beat.encoder_count);
		vel   = longint'(beat.measured_velocity);

		// Floor modulo into one revolution, then fold the upper half negative.
		ang = ((count % REV_COUNTS) + REV_COUNTS) % REV_COUNTS;
		if (ang >= REV_COUNTS / 2)
			ang -= REV_COUNTS;
		ang = saturate(ang, longint'(ANGLE_MIN), longint'(ANGLE_MAX));

		mag = (ang < 0) ? -ang : ang;
		if (mag < longint'(active_settings.deadband)) begin
			ang = 0;
			mag = 0;
		end

		// Past the cutoff the target is zero, but the angle is still remembered.
		if (mag > longint'(active_settings.cutoff))
			target = 0;
		else
			target = ang * longint'(active_settings.kp_gain)
				+ (ang - longint'(held_angle)) * longint'(active_settings.kd_gain);
		held_angle = ang[11:0];

		limit  = longint'(active_settings.velocity_limit);
		target = saturate(target, -limit, limit);
		drive  = saturate((target - vel) * longint'(active_settings.velocity_gain),
			longint'(DRIVE_MIN), longint'(DRIVE_MAX));

		result.drive_command = drive[15:0];
		result.angle         = ang[11:0];
		return result;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------

	// Most counts follow a slow random walk around upright that strays a little
	// past the cutoff, so the PD path and its derivative term are exercised
	// with realistic angle changes. The rest are raw noise and boundary angles.
	// Any angle is placed on a random revolution so the upper count bits move.
	function automatic logic signed [15:0] pick_encoder_count();
		int sel, span, ang;
		sel  = $urandom_range(0, 99);
		span = int'(active_settings.cutoff) + 64;
		ang  = 0;
		if (sel < 55) begin
			walk_angle += int'($urandom_range(0, 64)) - 32;
			if (walk_angle > span)
				walk_angle = span;
			if (walk_angle < -span)
				walk_angle = -span;
			ang = walk_angle;
		end else if (sel < 80) begin
			return 16'($urandom);
		end else begin
			case ($urandom_range(0, 7))
				0: ang = int'(active_settings.deadband);
				1: ang = -int'(active_settings.deadband);
				2: ang = int'(active_settings.deadband) - 1;
				3: ang = int'(active_settings.cutoff);
				4: ang = -int'(active_settings.cutoff) - 1;
				5: ang = int'(active_settings.cutoff) + 1;
				6: ang = 2047;
				default: ang = -2048;
			endcase
		end
		if (ang > 2047)
			ang = 2047;
		if (ang < -2048)
			ang = -2048;
		return 16'(ang + REV_COUNTS * (int'($urandom_range(0, 15)) - 8));
	endfunction

	function automatic logic signed [15:0] pick_velocity();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return 16'(int'($urandom_range(0, 6000)) - 3000);
		if (sel < 80)
			return 16'($urandom);
		case ($urandom_range(0, 3))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	// Raw register data: now and then zero or all ones (which the block masks to
	// the field's maximum), sometimes any 15-bit word, usually a working value.
	function automatic logic [CFG_DATA_W-1:0] pick_setting(int typical_hi);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		if (sel < 4)
			return CFG_DATA_W'($urandom);
		return CFG_DATA_W'($urandom_range(0, typical_hi));
	endfunction

	// ------------------------------------------------------------------------
	// Shared driving tasks
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// Offers one beat and returns in the time step of the edge that took it.
	// Valid is left high, so a caller that stops sending must lower it in that
	// same step (await_idle does).
	task automatic send_beat(in_item_t beat);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_commands.push_back(compute_control_step(beat));
		beats_sent++;
	endtask

	task automatic send_pair(int count, int vel);
		in_item_t beat;
		beat.encoder_count     = 16'(count);
		beat.measured_velocity = 16'(vel);
		send_beat(beat);
	endtask

	task automatic send_random_beats(int n);
		in_item_t beat;
		repeat (n) begin
			beat.encoder_count     = pick_encoder_count();
			beat.measured_velocity = pick_velocity();
			send_beat(beat);
		end
	endtask

	// Stops offering beats, waits for every owed result and lets the sequencer
	// wind down, so registers may be written afterwards.
	task automatic await_idle();
		in_valid <= 1'b0;
		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Each write lowers the enable and then waits for another edge, so that
	// back-to-back writes never raise and lower the enable in the same step.
	task automatic write_register(logic [CFG_INDEX_W-1:0] index,
			logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (index)
			REG_KP_GAIN:        active_settings.kp_gain        = value[7:0];
			REG_KD_GAIN:        active_settings.kd_gain        = value[7:0];
			REG_DEADBAND:       active_settings.deadband       = value[10:0];
			REG_CUTOFF:         active_settings.cutoff         = value[10:0];
			REG_VELOCITY_LIMIT: active_settings.velocity_limit = value[14:0];
			REG_VELOCITY_GAIN:  active_settings.velocity_gain  = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] kd,
			logic [CFG_DATA_W-1:0] db, logic [CFG_DATA_W-1:0] cut,
			logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] vg);
		write_register(REG_KP_GAIN, kp);
		write_register(REG_KD_GAIN, kd);
		write_register(REG_DEADBAND, db);
		write_register(REG_CUTOFF, cut);
		write_register(REG_VELOCITY_LIMIT, lim);
		write_register(REG_VELOCITY_GAIN, vg);
		settings_applied++;
	endtask

	// ------------------------------------------------------------------------
	// Receiver, checker and watchdog
	// ------------------------------------------------------------------------

	// The receiver stalls in short random bursts while idling is on. When a test
	// asks for a long hold it keeps ready low for the whole stretch, counting
	// the cycles here, so the output register and then the input back up.
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			stall_left   = LONG_HOLD_CYCLES;
		end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 3);
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every output beat is matched against the oldest owed result, field by
	// field. Signals are read just after the edge, so they hold the values that
	// the edge itself saw.
	always @(posedge clk) begin : result_checker
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_commands.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing owed: drive %0d angle %0d",
					results_checked, out_data.drive_command, out_data.angle));
			end else begin
				want = pending_commands.pop_front();
				if (out_data.drive_command !== want.drive_command)
					report_mismatch($sformatf("result %0d drive_command %0d, expected %0d",
						results_checked, out_data.drive_command, want.drive_command));
				if (out_data.angle !== want.angle)
					report_mismatch($sformatf("result %0d angle %0d, expected %0d",
						results_checked, out_data.angle, want.angle));
			end
		end
	end

	// Ends a hung run: too many cycles in a row with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles, %0d results still owed.",
				WATCHDOG_LIMIT, pending_commands.size());
			$display("pendulum_pd_velocity_controller regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset values: deadband and cutoff boundaries, wrap of the count at the
	// half revolution and at the 16-bit extremes, and drive saturation.
	task automatic test_default_settings();
		send_pair(0, 0);
		send_pair(69, 0);
		send_pair(70, 100);
		send_pair(-70, -100);
		send_pair(400, 0);
		send_pair(401, 0);
		send_pair(-401, 0);
		send_pair(2047, 32767);
		send_pair(2048, -32768);
		send_pair(4095, 0);
		send_pair(-32768, 32767);
		send_pair(32767, -32768);
		send_pair(REV_COUNTS + 200, -32768);
		await_idle();
	endtask

	// Writes to the unused indices must change nothing. Then every register is
	// taken to both ends of its range, including a deadband that swallows all
	// but the extreme angles and a cutoff that leaves only -2048 cut off.
	task automatic test_register_extremes();
		write_register(REG_SPARE_LO, '1);
		write_register(REG_SPARE_HI, 15'h0001);
		send_pair(300, 50);
		await_idle();

		apply_settings('1, '1, '0, '1, '1, '1);
		send_pair(2047, -32768);
		send_pair(2048, 32767);
		send_pair(1, 1);
		send_pair(-1, 0);
		send_pair(-2047, 32767);
		await_idle();

		apply_settings('0, '0, '0, '0, '0, '0);
		send_pair(0, 5);
		send_pair(1, -32768);
		await_idle();

		apply_settings(15'd10, 15'd3, '1, 15'd2047, 15'd500, 15'd1);
		send_pair(2046, 0);
		send_pair(2047, 0);
		send_pair(2048, 0);
		await_idle();
	endtask

	// Phases of random beats, each under its own random register setting.
	task automatic test_random_settings();
		repeat (7) begin
			apply_settings(pick_setting(40), pick_setting(60), pick_setting(150),
				pick_setting(1200), pick_setting(8000), pick_setting(12));
			walk_angle = 0;
			send_random_beats(150);
			await_idle();
		end
	endtask

	// The receiver holds off for a long stretch while beats keep coming, which
	// fills the output register and stalls the input. Afterwards the sender
	// waits for every owed result before it carries on.
	task automatic test_backpressure();
		apply_settings(CFG_DATA_W'(KP_RESET), CFG_DATA_W'(KD_RESET),
			CFG_DATA_W'(DB_RESET), CFG_DATA_W'(CUT_RESET),
			CFG_DATA_W'(LIMIT_RESET), CFG_DATA_W'(VG_RESET));
		hold_requests++;
		send_random_beats(12);
		in_valid <= 1'b0;
		while (pending_commands.size() != 0)
			@(posedge clk);
		send_random_beats(20);
		await_idle();
	endtask

	// Last part of the run: no idling on either side, beats back to back.
	task automatic test_streaming();
		idle_on = 1'b0;
		apply_settings(pick_setting(40), pick_setting(60), pick_setting(150),
			pick_setting(1200), pick_setting(8000), pick_setting(12));
		send_random_beats(150);
		await_idle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_register_extremes();
		test_random_settings();
		test_backpressure();
		test_streaming();

		// Nothing is owed now; a further stretch shows up any stray beat.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d control steps over %0d register settings.",
			results_checked, beats_sent, settings_applied);
		$display("Covered deadband and cutoff edges, angle wrap, gain and drive %s",
			"saturation, ignored register indices and a long output stall.");
		if (mismatches == 0)
			$display("pendulum_pd_velocity_controller regression: pass");
		else
			$display("pendulum_pd_velocity_controller regression: fail");
		$finish;
	end

endmodule
